[design/owmsr_pkg.sv]
// Package for the single-wire bus master: phase and action codes, operation
// codes, timing register set, result record and the command sequence tables.
// No dependencies.
package owmsr_pkg;

  // Number of ROM id bytes read by the read id operation
  localparam int unsigned IdBytes = 8;

  // Operation codes carried by a start item
  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_ID    = 3'd3;
  localparam logic [2:0] OP_TEMP  = 3'd4;

  // Timing register indexes on the configuration port
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_PRESENCE     = 3'd1;
  localparam logic [2:0] REG_WRITE_START  = 3'd2;
  localparam logic [2:0] REG_WRITE_HOLD   = 3'd3;
  localparam logic [2:0] REG_READ_LOW     = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE  = 3'd5;
  localparam logic [2:0] REG_READ_TAIL    = 3'd6;

  // Bus command bytes
  localparam logic [7:0] CMD_READ_ROM  = 8'h33;
  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_RISE = 4'd3,
    PH_WR_START = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } act_e;

  // Slot timing registers, in microsecond ticks
  typedef struct packed {
    logic [9:0] reset_low;
    logic [9:0] presence_wait;
    logic [9:0] write_start;
    logic [9:0] write_hold;
    logic [9:0] read_low;
    logic [9:0] read_sample;
    logic [9:0] read_tail;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic              presence;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [2:0]        byte_index;
    logic              last_byte;
    logic signed [7:0] temperature;
  } res_t;

  // Number of bus actions in each operation
  function automatic logic [3:0] seq_len(input logic [2:0] op);
    logic [3:0] len;
    case (op)
      OP_ID:   len = 4'd3;
      OP_TEMP: len = 4'd8;
      default: len = 4'd1;
    endcase
    return len;
  endfunction

  // Kind of bus action at a given step of an operation
  function automatic act_e seq_kind(input logic [2:0] op, input logic [2:0] st);
    act_e k;
    k = ACT_RESET;
    case (op)
      OP_WRITE: k = ACT_WRITE;
      OP_READ:  k = ACT_READ;
      OP_ID: begin
        case (st)
          3'd1:    k = ACT_WRITE;
          3'd2:    k = ACT_READ;
          default: k = ACT_RESET;
        endcase
      end
      OP_TEMP: begin
        case (st) inside
          3'd1, 3'd2, 3'd4, 3'd5: k = ACT_WRITE;
          3'd6, 3'd7:             k = ACT_READ;
          default:                k = ACT_RESET;
        endcase
      end
      default: k = ACT_RESET;
    endcase
    return k;
  endfunction

  // Command byte sent at a given write step of an operation
  function automatic logic [7:0] seq_byte(input logic [2:0] op, input logic [2:0] st);
    logic [7:0] b;
    b = 8'h00;
    case (op)
      OP_ID: begin
        if (st == 3'd1) b = CMD_READ_ROM;
      end
      OP_TEMP: begin
        case (st) inside
          3'd1, 3'd4: b = CMD_SKIP_ROM;
          3'd2:       b = CMD_CONVERT;
          3'd5:       b = CMD_READ_PAD;
          default:    b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[design/owmsr_cfg.sv]
// Slot timing register file for the single-wire bus master.
// Depends on owmsr_pkg.
module owmsr_cfg
  import owmsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_wdata_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Register decode; index beyond the list is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RESET_LOW:   cfg_d.reset_low     = cfg_wdata_i;
        REG_PRESENCE:    cfg_d.presence_wait = cfg_wdata_i;
        REG_WRITE_START: cfg_d.write_start   = cfg_wdata_i;
        REG_WRITE_HOLD:  cfg_d.write_hold    = cfg_wdata_i;
        REG_READ_LOW:    cfg_d.read_low      = cfg_wdata_i;
        REG_READ_SAMPLE: cfg_d.read_sample   = cfg_wdata_i;
        REG_READ_TAIL:   cfg_d.read_tail     = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= 10'd541;
      cfg_q.presence_wait <= 10'd64;
      cfg_q.write_start   <= 10'd16;
      cfg_q.write_hold    <= 10'd49;
      cfg_q.read_low      <= 10'd8;
      cfg_q.read_sample   <= 10'd8;
      cfg_q.read_tail     <= 10'd42;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/owmsr_core.sv]
// Bus sequencer for the single-wire bus master: slot timer, bit shifter and
// operation sequencing, resolving one accepted transaction per cycle.
// Depends on owmsr_pkg.
module owmsr_core
  import owmsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       kind_i,
  input  logic [2:0] op_i,
  input  logic [7:0] write_value_i,
  input  logic       line_level_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e     phase_q, phase_d;
  logic [9:0] tick_q, tick_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] seq_q, seq_d;
  logic [2:0] byte_cnt_q, byte_cnt_d;
  logic [7:0] low_hold_q, low_hold_d;
  logic       present_q, present_d;
  logic [2:0] op_q, op_d;

  logic [9:0] tick_inc;
  logic [9:0] limit;
  logic       timer_hit;
  logic       act_fin;
  logic       enter;
  logic       fin;
  logic [3:0] byte_next;
  act_e       cur_kind;
  act_e       new_kind;

  assign cur_kind  = seq_kind(op_q, seq_q[2:0]);
  assign byte_next = {1'b0, byte_cnt_q} + 4'd1;

  // Next state and result for one transaction
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    seq_d      = seq_q;
    byte_cnt_d = byte_cnt_q;
    low_hold_d = low_hold_q;
    present_d  = present_q;
    op_d       = op_q;
    act_fin    = 1'b0;
    enter      = 1'b0;
    fin        = 1'b0;
    new_kind   = ACT_RESET;
    res_o      = '0;

    // Slot timer: limit follows the current phase
    tick_inc = tick_q + 10'd1;
    unique case (phase_q)
      PH_RST_LOW:  limit = cfg_i.reset_low;
      PH_RST_WAIT: limit = cfg_i.presence_wait;
      PH_WR_START: limit = cfg_i.write_start;
      PH_WR_HOLD:  limit = cfg_i.write_hold;
      PH_RD_LOW:   limit = cfg_i.read_low;
      PH_RD_WAIT:  limit = cfg_i.read_sample;
      PH_RD_TAIL:  limit = cfg_i.read_tail;
      default:     limit = 10'd0;
    endcase
    timer_hit = (tick_inc >= limit);

    if (kind_i) begin
      // Start is taken only while idle and for a known operation
      if (phase_q == PH_IDLE && op_i <= OP_TEMP) begin
        op_d       = op_i;
        seq_d      = 4'd0;
        byte_cnt_d = 3'd0;
        if (op_i == OP_WRITE) shift_d = write_value_i;
        enter      = 1'b1;
      end
    end else if (phase_q != PH_IDLE) begin
      if (phase_q != PH_RST_RISE) tick_d = timer_hit ? 10'd0 : tick_inc;
      unique case (phase_q)
        PH_RST_LOW: begin
          if (timer_hit) phase_d = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (timer_hit) begin
            present_d = ~line_level_i;
            if (!line_level_i) phase_d = PH_RST_RISE;
            else act_fin = 1'b1;
          end
        end
        PH_RST_RISE: begin
          if (line_level_i) act_fin = 1'b1;
        end
        PH_WR_START: begin
          if (timer_hit) phase_d = PH_WR_HOLD;
        end
        PH_WR_HOLD: begin
          if (timer_hit) begin
            shift_d = {1'b0, shift_q[7:1]};
            if (bit_q == 3'd7) begin
              act_fin = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PH_WR_START;
            end
          end
        end
        PH_RD_LOW: begin
          if (timer_hit) phase_d = PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          if (timer_hit) begin
            shift_d = {line_level_i, shift_q[7:1]};
            phase_d = PH_RD_TAIL;
          end
        end
        PH_RD_TAIL: begin
          if (timer_hit) begin
            if (bit_q == 3'd7) begin
              act_fin = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PH_RD_LOW;
            end
          end
        end
        default: phase_d = phase_q;
      endcase
    end

    // End of one bus action: report read bytes, move to the next step
    if (act_fin) begin
      if (cur_kind == ACT_READ) begin
        res_o.data_valid = 1'b1;
        res_o.data_byte  = shift_q;
        if (op_q == OP_ID) begin
          res_o.byte_index = byte_cnt_q;
          if (byte_next >= 4'(IdBytes)) begin
            res_o.last_byte = 1'b1;
            fin             = 1'b1;
          end else begin
            byte_cnt_d = byte_next[2:0];
            enter      = 1'b1;
          end
        end else if (op_q == OP_TEMP && seq_q[2:0] == 3'd6) begin
          // low scratchpad byte, keep it for the final value
          low_hold_d = shift_q;
          seq_d      = 4'd7;
          enter      = 1'b1;
        end else if (op_q == OP_TEMP) begin
          res_o.byte_index  = 3'd1;
          res_o.last_byte   = 1'b1;
          res_o.temperature = $signed({shift_q[3:0], low_hold_q[7:4]});
          fin               = 1'b1;
        end else begin
          res_o.last_byte = 1'b1;
          fin             = 1'b1;
        end
      end else begin
        seq_d = seq_q + 4'd1;
        if (seq_d >= seq_len(op_q)) fin = 1'b1;
        else enter = 1'b1;
      end
    end

    // Launch the action at the current step
    if (enter) begin
      new_kind = seq_kind(op_d, seq_d[2:0]);
      tick_d   = 10'd0;
      bit_d    = 3'd0;
      unique case (new_kind)
        ACT_RESET: phase_d = PH_RST_LOW;
        ACT_WRITE: begin
          if (op_d != OP_WRITE) shift_d = seq_byte(op_d, seq_d[2:0]);
          phase_d = PH_WR_START;
        end
        ACT_READ: begin
          shift_d = 8'h00;
          phase_d = PH_RD_LOW;
        end
        default: phase_d = PH_RST_LOW;
      endcase
    end

    if (fin) phase_d = PH_IDLE;

    // Line drive and status after this transaction
    unique case (phase_d) inside
      PH_RST_LOW, PH_WR_START, PH_RD_LOW: res_o.drive_low = 1'b1;
      PH_WR_HOLD:                         res_o.drive_low = ~shift_d[0];
      default:                            res_o.drive_low = 1'b0;
    endcase
    res_o.busy     = (phase_d != PH_IDLE);
    res_o.done     = fin;
    res_o.presence = present_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= 10'd0;
      bit_q      <= 3'd0;
      shift_q    <= 8'h00;
      seq_q      <= 4'd0;
      byte_cnt_q <= 3'd0;
      low_hold_q <= 8'h00;
      present_q  <= 1'b0;
      op_q       <= OP_RESET;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      seq_q      <= seq_d;
      byte_cnt_q <= byte_cnt_d;
      low_hold_q <= low_hold_d;
      present_q  <= present_d;
      op_q       <= op_d;
    end
  end

endmodule

[design/one_wire_master_sensor_reader.sv]
// Single-wire bus master top level: handshake, timing registers, sequencer
// and result register. Depends on owmsr_pkg, owmsr_cfg and owmsr_core.
//
// Every input transaction is either a one-microsecond tick or a start
// command, and each one yields exactly one result transaction. A transaction
// is resolved in the cycle it is accepted: the sequencer state updates at
// that clock edge and the result lands in the output register, so the block
// takes one transaction per clock cycle for as long as results are taken;
// the one-entry result register is the only stall point, and a new
// transaction is accepted in the same cycle the waiting result is taken.
// Bus timing is counted purely in ticks; the timing registers may be
// written only while no operation is in progress. There is no
// initialization sweep after reset.
module one_wire_master_sensor_reader
  import owmsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [2:0]        op_i,
  input  logic [7:0]        write_value_i,
  input  logic              line_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              drive_low_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic              presence_o,
  output logic              data_valid_o,
  output logic [7:0]        data_byte_o,
  output logic [2:0]        byte_index_o,
  output logic              last_byte_o,
  output logic signed [7:0] temperature_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [9:0]        cfg_wdata_i
);

  cfg_t cfg;
  res_t res_next;
  res_t res_q;
  logic out_valid_q, out_valid_d;
  logic accept;

  owmsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owmsr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .kind_i        (kind_i),
    .op_i          (op_i),
    .write_value_i (write_value_i),
    .line_level_i  (line_level_i),
    .cfg_i         (cfg),
    .res_o         (res_next)
  );

  // Accept when the result register is free or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_next;
  end

  assign out_valid_o   = out_valid_q;
  assign drive_low_o   = res_q.drive_low;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign presence_o    = res_q.presence;
  assign data_valid_o  = res_q.data_valid;
  assign data_byte_o   = res_q.data_byte;
  assign byte_index_o  = res_q.byte_index;
  assign last_byte_o   = res_q.last_byte;
  assign temperature_o = res_q.temperature;

endmodule

[design/owmsr_checker.sv]
// Port-level checks for the single-wire bus master, bound to the top level.
// Depends on one_wire_master_sensor_reader port names only.
module owmsr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              busy_res_o,
  input logic              done_res_o,
  input logic              data_valid_o,
  input logic [7:0]        data_byte_o,
  input logic [2:0]        byte_index_o,
  input logic              last_byte_o,
  input logic signed [7:0] temperature_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(done_res_o) && $stable(temperature_o))
    else $error("stalled result changed");

  // A finished operation is no longer busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done while busy");

  // A read byte only appears inside a running or finishing operation
  a_byte_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> busy_res_o || done_res_o)
    else $error("byte outside an operation");

  // Byte fields are cleared when no byte is reported
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> data_byte_o == 8'h00 && byte_index_o == 3'd0
      && !last_byte_o)
    else $error("byte fields set without a byte");

  // Temperature only on the final byte of an operation
  a_temp_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && temperature_o != 8'sd0 |-> done_res_o && last_byte_o)
    else $error("temperature outside final byte");

endmodule

bind one_wire_master_sensor_reader owmsr_checker u_owmsr_checker (.*);

[verif/one_wire_master_sensor_reader_checker.sv]
`timescale 1ns / 100ps
// Result checker for the single-wire bus master: watches both handshakes and the
// timing register port, predicts every result and compares it. Uses owmsr_pkg.
module one_wire_master_sensor_reader_checker
  import owmsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              kind_i,
  input  logic [2:0]        op_i,
  input  logic [7:0]        write_value_i,
  input  logic              line_level_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              drive_low_i,
  input  logic              busy_res_i,
  input  logic              done_res_i,
  input  logic              presence_i,
  input  logic              data_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic [2:0]        byte_index_i,
  input  logic              last_byte_i,
  input  logic signed [7:0] temperature_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [9:0]        cfg_wdata_i,
  output int                mismatches_o,
  output int                pending_o,
  output logic              busy_o
);

  // Bus master state as predicted
  phase_e     bus_phase;
  logic [9:0] slot_ticks;
  logic [2:0] bit_idx;
  logic [7:0] shift_reg;
  logic [3:0] seq_step;
  logic [2:0] rom_byte_idx;
  logic [7:0] scratch_low;
  logic       device_seen;
  logic [2:0] cur_op;
  logic [9:0] slot_limit [0:6];

  // Results predicted but not yet seen on the output channel
  res_t bus_results_q[$];

  // Bus action performed at a given step of an operation
  function automatic act_e action_at(input logic [2:0] o, input logic [2:0] s);
    act_e a;
    a = ACT_RESET;
    if (o == OP_WRITE) begin
      a = ACT_WRITE;
    end else if (o == OP_READ) begin
      a = ACT_READ;
    end else if (o == OP_ID) begin
      if (s == 3'd1) a = ACT_WRITE;
      else if (s >= 3'd2) a = ACT_READ;
    end else if (o == OP_TEMP) begin
      if (s >= 3'd6) a = ACT_READ;
      else if (s != 3'd0 && s != 3'd3) a = ACT_WRITE;
    end
    return a;
  endfunction

  // Command byte shifted out by a write step of a composite operation
  function automatic logic [7:0] command_at(input logic [2:0] o, input logic [2:0] s);
    logic [7:0] c;
    c = 8'h00;
    if (o == OP_ID && s == 3'd1) begin
      c = CMD_READ_ROM;
    end else if (o == OP_TEMP) begin
      if (s == 3'd1 || s == 3'd4) c = CMD_SKIP_ROM;
      else if (s == 3'd2) c = CMD_CONVERT;
      else if (s == 3'd5) c = CMD_READ_PAD;
    end
    return c;
  endfunction

  function automatic logic [3:0] actions_in(input logic [2:0] o);
    if (o == OP_ID) return 4'd3;
    if (o == OP_TEMP) return 4'd8;
    return 4'd1;
  endfunction

  // Count one tick; true when the slot time has run out
  function automatic logic timer_hit(input logic [9:0] lim);
    slot_ticks = slot_ticks + 10'd1;
    if (slot_ticks >= lim) begin
      slot_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_bus_model();
    bus_phase    = PH_IDLE;
    slot_ticks   = '0;
    bit_idx      = '0;
    shift_reg    = '0;
    seq_step     = '0;
    rom_byte_idx = '0;
    scratch_low  = '0;
    device_seen  = 1'b0;
    cur_op       = OP_RESET;
    slot_limit[REG_RESET_LOW]   = 10'd541;
    slot_limit[REG_PRESENCE]    = 10'd64;
    slot_limit[REG_WRITE_START] = 10'd16;
    slot_limit[REG_WRITE_HOLD]  = 10'd49;
    slot_limit[REG_READ_LOW]    = 10'd8;
    slot_limit[REG_READ_SAMPLE] = 10'd8;
    slot_limit[REG_READ_TAIL]   = 10'd42;
  endtask

  task automatic begin_action();
    act_e a;
    a = action_at(cur_op, seq_step[2:0]);
    slot_ticks = '0;
    bit_idx = '0;
    if (a == ACT_RESET) begin
      bus_phase = PH_RST_LOW;
    end else if (a == ACT_WRITE) begin
      if (cur_op != OP_WRITE) shift_reg = command_at(cur_op, seq_step[2:0]);
      bus_phase = PH_WR_START;
    end else begin
      shift_reg = '0;
      bus_phase = PH_RD_LOW;
    end
  endtask

  // Finish the current bus action; fin marks the end of the whole operation
  task automatic close_action(inout res_t r, output logic fin);
    act_e a;
    int   next_idx;
    a = action_at(cur_op, seq_step[2:0]);
    fin = 1'b0;
    if (a == ACT_READ) begin
      r.data_valid = 1'b1;
      r.data_byte  = shift_reg;
      if (cur_op == OP_ID) begin
        r.byte_index = rom_byte_idx;
        next_idx = rom_byte_idx + 1;
        if (next_idx >= IdBytes) begin
          r.last_byte = 1'b1;
          fin = 1'b1;
        end else begin
          rom_byte_idx = rom_byte_idx + 3'd1;
          begin_action();
        end
      end else if (cur_op == OP_TEMP && seq_step[2:0] == 3'd6) begin
        // low scratchpad byte, the high one follows
        scratch_low = shift_reg;
        seq_step = 4'd7;
        begin_action();
      end else if (cur_op == OP_TEMP) begin
        r.byte_index  = 3'd1;
        r.last_byte   = 1'b1;
        r.temperature = {shift_reg[3:0], scratch_low[7:4]};
        fin = 1'b1;
      end else begin
        r.last_byte = 1'b1;
        fin = 1'b1;
      end
    end else begin
      seq_step = seq_step + 4'd1;
      if (seq_step >= actions_in(cur_op)) fin = 1'b1;
      else begin_action();
    end
  endtask

  // One microsecond tick while an operation runs
  task automatic take_tick(input logic ln, inout res_t r, output logic fin);
    fin = 1'b0;
    case (bus_phase)
      PH_RST_LOW: begin
        if (timer_hit(slot_limit[REG_RESET_LOW])) bus_phase = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (timer_hit(slot_limit[REG_PRESENCE])) begin
          device_seen = !ln;
          if (device_seen) bus_phase = PH_RST_RISE;
          else close_action(r, fin);
        end
      end
      PH_RST_RISE: begin
        if (ln) close_action(r, fin);
      end
      PH_WR_START: begin
        if (timer_hit(slot_limit[REG_WRITE_START])) bus_phase = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        if (timer_hit(slot_limit[REG_WRITE_HOLD])) begin
          shift_reg = shift_reg >> 1;
          if (bit_idx == 3'd7) begin
            close_action(r, fin);
          end else begin
            bit_idx = bit_idx + 3'd1;
            bus_phase = PH_WR_START;
          end
        end
      end
      PH_RD_LOW: begin
        if (timer_hit(slot_limit[REG_READ_LOW])) bus_phase = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (timer_hit(slot_limit[REG_READ_SAMPLE])) begin
          shift_reg = {ln, shift_reg[7:1]};
          bus_phase = PH_RD_TAIL;
        end
      end
      PH_RD_TAIL: begin
        if (timer_hit(slot_limit[REG_READ_TAIL])) begin
          if (bit_idx == 3'd7) begin
            close_action(r, fin);
          end else begin
            bit_idx = bit_idx + 3'd1;
            bus_phase = PH_RD_LOW;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Advance the bus master by one input transaction and build its result
  task automatic step_bus_master(input logic k, input logic [2:0] o, input logic [7:0] wv,
                                 input logic ln, output res_t r);
    logic fin;
    r = '0;
    fin = 1'b0;
    if (k) begin
      // starts while busy and undefined op codes are dropped
      if (bus_phase == PH_IDLE && o <= OP_TEMP) begin
        cur_op = o;
        seq_step = '0;
        rom_byte_idx = '0;
        if (o == OP_WRITE) shift_reg = wv;
        begin_action();
      end
    end else if (bus_phase != PH_IDLE) begin
      take_tick(ln, r, fin);
      if (fin) bus_phase = PH_IDLE;
    end
    if (bus_phase == PH_RST_LOW || bus_phase == PH_WR_START || bus_phase == PH_RD_LOW)
      r.drive_low = 1'b1;
    else if (bus_phase == PH_WR_HOLD)
      r.drive_low = !shift_reg[0];
    r.busy     = (bus_phase != PH_IDLE);
    r.done     = fin;
    r.presence = device_seen;
  endtask

  // Register writes, result comparison, then prediction for the new transaction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t seen;
    res_t want;
    if (!rst_ni) begin
      clear_bus_model();
      bus_results_q.delete();
      mismatches_o = 0;
      pending_o <= 0;
      busy_o <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i <= REG_READ_TAIL) slot_limit[cfg_index_i] = cfg_wdata_i;

      if (out_valid_i && out_ready_i) begin
        seen.drive_low   = drive_low_i;
        seen.busy        = busy_res_i;
        seen.done        = done_res_i;
        seen.presence    = presence_i;
        seen.data_valid  = data_valid_i;
        seen.data_byte   = data_byte_i;
        seen.byte_index  = byte_index_i;
        seen.last_byte   = last_byte_i;
        seen.temperature = temperature_i;
        if (bus_results_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t ns: result with nothing outstanding, byte %h temp %0d",
                     $time, seen.data_byte, seen.temperature);
        end else begin
          want = bus_results_q.pop_front();
          if (seen.drive_low !== want.drive_low || seen.busy !== want.busy ||
              seen.done !== want.done || seen.presence !== want.presence ||
              seen.data_valid !== want.data_valid || seen.data_byte !== want.data_byte ||
              seen.byte_index !== want.byte_index || seen.last_byte !== want.last_byte ||
              seen.temperature !== want.temperature) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%0t ns: expected drv %b busy %b done %b pres %b dv %b byte %h idx %0d",
                       $time, want.drive_low, want.busy, want.done, want.presence,
                       want.data_valid, want.data_byte, want.byte_index);
              $display("    last %b temp %0d", want.last_byte, want.temperature);
              $display("%0t ns: actual   drv %b busy %b done %b pres %b dv %b byte %h idx %0d",
                       $time, seen.drive_low, seen.busy, seen.done, seen.presence,
                       seen.data_valid, seen.data_byte, seen.byte_index);
              $display("    last %b temp %0d", seen.last_byte, seen.temperature);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        step_bus_master(kind_i, op_i, write_value_i, line_level_i, want);
        bus_results_q.push_back(want);
      end

      busy_o <= (bus_phase != PH_IDLE);
      pending_o <= bus_results_q.size();
    end
  end

endmodule

[verif/one_wire_master_sensor_reader_tb.sv]
`timescale 1ns / 100ps
// Top of the bus master testbench: clock, reset, stimulus and verdict.
// Depends on owmsr_pkg, one_wire_master_sensor_reader and its checker.
module one_wire_master_sensor_reader_tb;
  import owmsr_pkg::*;

  localparam int unsigned RunLimitNs  = 4_000_000;
  localparam int          RandomItems = 650;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              kind_i        = 1'b0;
  logic [2:0]        op_i          = OP_RESET;
  logic [7:0]        write_value_i = 8'h00;
  logic              line_level_i  = 1'b1;
  logic              out_ready_i   = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [2:0]        cfg_index_i   = REG_RESET_LOW;
  logic [9:0]        cfg_wdata_i   = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              drive_low_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic              presence_o;
  logic              data_valid_o;
  logic [7:0]        data_byte_o;
  logic [2:0]        byte_index_o;
  logic              last_byte_o;
  logic signed [7:0] temperature_o;

  int          mismatch_total;
  int          pending_results;
  logic        model_busy;
  int          items_sent = 0;
  int          burst_left = 0;
  ready_mode_e stall_mode = RDY_ALWAYS;
  int          stall_left = 0;

  always #2 clk_i = ~clk_i;

  one_wire_master_sensor_reader i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .op_i          (op_i),
    .write_value_i (write_value_i),
    .line_level_i  (line_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_low_o   (drive_low_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .presence_o    (presence_o),
    .data_valid_o  (data_valid_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .last_byte_o   (last_byte_o),
    .temperature_o (temperature_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  one_wire_master_sensor_reader_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .op_i          (op_i),
    .write_value_i (write_value_i),
    .line_level_i  (line_level_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_low_i   (drive_low_o),
    .busy_res_i    (busy_res_o),
    .done_res_i    (done_res_o),
    .presence_i    (presence_o),
    .data_valid_i  (data_valid_o),
    .data_byte_i   (data_byte_o),
    .byte_index_i  (byte_index_o),
    .last_byte_i   (last_byte_o),
    .temperature_i (temperature_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatch_total),
    .pending_o     (pending_results),
    .busy_o        (model_busy)
  );

  // Result side: the stall pattern changes in runs of random length
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= ready_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:    out_ready_i <= ~out_ready_i;
    endcase
  end

  // Offer one transaction and hold it until taken; bursts with random gaps between
  task automatic send_item(input logic k, input logic [2:0] o, input logic [7:0] wv,
                           input logic ln);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    op_i          <= o;
    write_value_i <= wv;
    line_level_i  <= ln;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Microsecond tick; the line is high with the given percentage
  task automatic tick_line(input int pct);
    logic [2:0] o;
    logic [7:0] v;
    o = 3'($urandom);
    v = 8'($urandom);
    send_item(1'b0, o, v, $urandom_range(0, 99) < pct);
  endtask

  // Start an operation and tick until the master is idle again. Stray starts
  // land mid-operation; the loop only ends after a plain tick seen idle.
  task automatic run_op(input logic [2:0] o, input logic [7:0] v, input int pct,
                        input int noise);
    logic [2:0] stray_op;
    logic [7:0] stray_val;
    logic       last_tick;
    send_item(1'b1, o, v, 1'($urandom_range(0, 1)));
    last_tick = 1'b0;
    while (model_busy || !last_tick) begin
      if ($urandom_range(0, 99) < noise) begin
        stray_op  = 3'($urandom);
        stray_val = 8'($urandom);
        send_item(1'b1, stray_op, stray_val, 1'($urandom_range(0, 1)));
        last_tick = 1'b0;
      end else begin
        tick_line(pct);
        last_tick = 1'b1;
      end
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_timing(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                             input logic [9:0] wr_start, input logic [9:0] wr_hold,
                             input logic [9:0] rd_low, input logic [9:0] rd_sample,
                             input logic [9:0] rd_tail);
    write_reg(REG_RESET_LOW, rst_low);
    write_reg(REG_PRESENCE, pres_wait);
    write_reg(REG_WRITE_START, wr_start);
    write_reg(REG_WRITE_HOLD, wr_hold);
    write_reg(REG_READ_LOW, rd_low);
    write_reg(REG_READ_SAMPLE, rd_sample);
    write_reg(REG_READ_TAIL, rd_tail);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly the shortest slots so that many operations fit into the run
  function automatic logic [9:0] rand_ticks();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return 10'd1;
    if (p < 9) return 10'($urandom_range(2, 4));
    return 10'($urandom_range(5, 12));
  endfunction

  initial begin : stimulus
    int         rand_start;
    int         seg_start;
    int         pick;
    logic [2:0] o;
    logic [7:0] v;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed operations at the shortest timing
    load_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    run_op(OP_RESET, 8'h00, 100, 0);   // nobody answers
    run_op(OP_RESET, 8'h00, 30, 0);    // answer, then wait for the line to rise
    run_op(OP_WRITE, 8'h00, 50, 0);
    run_op(OP_WRITE, 8'hFF, 50, 0);
    run_op(OP_READ, 8'h00, 100, 0);    // all ones
    run_op(OP_READ, 8'hFF, 0, 0);      // all zeros
    run_op(OP_ID, 8'h00, 60, 0);
    run_op(OP_TEMP, 8'h00, 60, 0);
    run_op(OP_TEMP, 8'h00, 50, 30);    // starts arriving while busy
    o = OP_TEMP;
    repeat (3) begin
      o = o + 3'd1;                    // undefined op codes leave the master idle
      send_item(1'b1, o, 8'hA5, 1'b0);
      tick_line(50);
    end
    drain();

    // Random operations under changing timing
    rand_start = items_sent;
    seg_start = -1000;
    while (items_sent - rand_start < RandomItems) begin
      if (items_sent - seg_start > 300) begin
        drain();
        load_timing(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(),
                    rand_ticks(), rand_ticks(), rand_ticks());
        seg_start = items_sent;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // idle bus: lone ticks and undefined op codes
        repeat ($urandom_range(1, 3)) begin
          o = OP_TEMP + 3'($urandom_range(1, 3));
          v = 8'($urandom);
          if ($urandom_range(0, 1) == 1) send_item(1'b1, o, v, 1'($urandom_range(0, 1)));
          else tick_line(50);
        end
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 4) o = OP_RESET;
        else if (pick < 9) o = OP_WRITE;
        else if (pick < 14) o = OP_READ;
        else if (pick < 17) o = OP_ID;
        else o = OP_TEMP;
        v = 8'($urandom);
        run_op(o, v, $urandom_range(10, 90), 4);
      end
    end
    drain();

    if (mismatch_total == 0 && pending_results == 0) begin
      $display("one_wire_master_sensor_reader_tb passed");
    end else begin
      $display("one_wire_master_sensor_reader_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitNs);
    $display("one_wire_master_sensor_reader_tb failed");
    $finish;
  end

endmodule
